// ----- design/approach_risk_qualifier_macros.svh -----
// Assertion macros for the approach risk qualifier.
// Included by the top level; no other dependencies.
`ifndef APPROACH_RISK_QUALIFIER_MACROS_SVH
`define APPROACH_RISK_QUALIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define ARQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ARQ_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARQ_ASSERT(label, clk, rst_n, prop, msg)
`define ARQ_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/arq_pkg.sv -----
// Shared types and constants for the approach risk qualifier.
// No dependencies.
`timescale 1ns / 1ps

package arq_pkg;

	localparam int CONF_W = 7;
	localparam int LIM_W = 15;
	localparam int MEAS_W = 16;
	localparam int TIME_W = 32;
	localparam int HYST_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RISK_DIST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RISK_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR = 3'd6;

	// reset values
	localparam logic [CONF_W-1:0] RST_MIN_CONF = 7'd50;
	localparam logic [LIM_W-1:0] RST_MAX_DIST = 15'd1000;
	localparam logic [LIM_W-1:0] RST_MAX_SPEED = 15'd3000;
	localparam logic [LIM_W-1:0] RST_RISK_DIST = 15'd300;
	localparam logic [LIM_W-1:0] RST_RISK_SPEED = 15'd150;
	localparam logic [HYST_W-1:0] RST_CONFIRM = 16'd100;
	localparam logic [HYST_W-1:0] RST_CLEAR = 16'd1000;

	// risk levels
	localparam logic [1:0] LEVEL_NONE = 2'd0;
	localparam logic [1:0] LEVEL_LOW = 2'd1;
	localparam logic [1:0] LEVEL_MEDIUM = 2'd2;
	localparam logic [1:0] LEVEL_HIGH = 2'd3;

	// fault codes
	localparam logic FAULT_NONE = 1'b0;
	localparam logic FAULT_REAR_SENSOR = 1'b1;

	typedef struct packed {
		logic [CONF_W-1:0] min_conf;
		logic [LIM_W-1:0] max_dist;
		logic [LIM_W-1:0] max_speed;
		logic [LIM_W-1:0] risk_dist;
		logic [LIM_W-1:0] risk_speed;
		logic [HYST_W-1:0] confirm;
		logic [HYST_W-1:0] clear;
	} cfg_t;

	typedef struct packed {
		logic ok;
		logic threat;
		logic [1:0] level;
	} class_t;

endpackage

// ----- design/arq_cfg_regs.sv -----
// Configuration register file for the approach risk qualifier.
// Depends on arq_pkg.
`timescale 1ns / 1ps

module arq_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [arq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arq_pkg::CFG_DATA_W-1:0] cfg_data,
	output arq_pkg::cfg_t cfg
);

	arq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_conf <= arq_pkg::RST_MIN_CONF;
			cfg_q.max_dist <= arq_pkg::RST_MAX_DIST;
			cfg_q.max_speed <= arq_pkg::RST_MAX_SPEED;
			cfg_q.risk_dist <= arq_pkg::RST_RISK_DIST;
			cfg_q.risk_speed <= arq_pkg::RST_RISK_SPEED;
			cfg_q.confirm <= arq_pkg::RST_CONFIRM;
			cfg_q.clear <= arq_pkg::RST_CLEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				arq_pkg::REG_MIN_CONF: cfg_q.min_conf <= cfg_data[arq_pkg::CONF_W-1:0];
				arq_pkg::REG_MAX_DIST: cfg_q.max_dist <= cfg_data[arq_pkg::LIM_W-1:0];
				arq_pkg::REG_MAX_SPEED: cfg_q.max_speed <= cfg_data[arq_pkg::LIM_W-1:0];
				arq_pkg::REG_RISK_DIST: cfg_q.risk_dist <= cfg_data[arq_pkg::LIM_W-1:0];
				arq_pkg::REG_RISK_SPEED: cfg_q.risk_speed <= cfg_data[arq_pkg::LIM_W-1:0];
				arq_pkg::REG_CONFIRM: cfg_q.confirm <= cfg_data[arq_pkg::HYST_W-1:0];
				arq_pkg::REG_CLEAR: cfg_q.clear <= cfg_data[arq_pkg::HYST_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/arq_classify.sv -----
// Validation and risk level classification of one measurement.
// Depends on arq_pkg; purely combinational.
`timescale 1ns / 1ps

module arq_classify (
	input  arq_pkg::cfg_t cfg,
	input  logic sensor_healthy,
	input  logic [arq_pkg::CONF_W-1:0] confidence,
	input  logic signed [arq_pkg::MEAS_W-1:0] distance_cm,
	input  logic signed [arq_pkg::MEAS_W-1:0] speed_cm_s,
	output arq_pkg::class_t cls
);

	logic [arq_pkg::LIM_W-1:0] dist_mag;
	logic [arq_pkg::LIM_W-1:0] speed_mag;
	logic [arq_pkg::LIM_W:0] risk_dist_x2;
	logic dist_ok;
	logic speed_ok;
	logic close_obj;
	logic fast_obj;

	// sign bit set means negative, always out of range
	assign dist_mag = distance_cm[arq_pkg::LIM_W-1:0];
	assign speed_mag = speed_cm_s[arq_pkg::LIM_W-1:0];
	assign dist_ok = !distance_cm[arq_pkg::MEAS_W-1] && (dist_mag <= cfg.max_dist);
	assign speed_ok = !speed_cm_s[arq_pkg::MEAS_W-1] && (speed_mag <= cfg.max_speed);

	assign close_obj = dist_mag <= cfg.risk_dist;
	assign fast_obj = speed_mag >= cfg.risk_speed;
	assign risk_dist_x2 = {cfg.risk_dist, 1'b0};

	always_comb begin
		cls.ok = sensor_healthy && (confidence >= cfg.min_conf) && dist_ok && speed_ok;
		cls.threat = close_obj && fast_obj;
		if (!cls.ok) begin
			cls.level = arq_pkg::LEVEL_NONE;
		end else if (cls.threat) begin
			cls.level = arq_pkg::LEVEL_HIGH;
		end else if (close_obj || fast_obj) begin
			cls.level = arq_pkg::LEVEL_MEDIUM;
		end else if ({1'b0, dist_mag} <= risk_dist_x2) begin
			cls.level = arq_pkg::LEVEL_LOW;
		end else begin
			cls.level = arq_pkg::LEVEL_NONE;
		end
	end

endmodule

// ----- design/arq_hysteresis.sv -----
// Threat confirm / clear hysteresis state and its update.
// Depends on arq_pkg.
`timescale 1ns / 1ps

module arq_hysteresis (
	input  logic clk,
	input  logic arst_n,
	input  logic commit,
	input  arq_pkg::class_t cls,
	input  logic [arq_pkg::TIME_W-1:0] now,
	input  logic [arq_pkg::HYST_W-1:0] confirm,
	input  logic [arq_pkg::HYST_W-1:0] clear,
	output logic high_next
);

	logic [arq_pkg::TIME_W-1:0] onset_q;
	logic [arq_pkg::TIME_W-1:0] safe_since_q;
	logic ongoing_q;
	logic high_q;
	logic [arq_pkg::TIME_W-1:0] onset_eff;
	logic [arq_pkg::TIME_W-1:0] threat_age;
	logic [arq_pkg::TIME_W-1:0] safe_age;

	// a fresh threat starts now, so its age is zero
	assign onset_eff = ongoing_q ? onset_q : now;
	assign threat_age = now - onset_eff;
	assign safe_age = now - safe_since_q;

	always_comb begin
		high_next = high_q;
		if (cls.threat) begin
			if (threat_age >= {{(arq_pkg::TIME_W-arq_pkg::HYST_W){1'b0}}, confirm})
				high_next = 1'b1;
		end else begin
			if (safe_age >= {{(arq_pkg::TIME_W-arq_pkg::HYST_W){1'b0}}, clear})
				high_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_q <= '0;
			safe_since_q <= '0;
			ongoing_q <= 1'b0;
			high_q <= 1'b0;
		end else if (commit && cls.ok) begin
			high_q <= high_next;
			onset_q <= onset_eff;
			ongoing_q <= cls.threat;
			if (cls.threat)
				safe_since_q <= now;
		end
	end

endmodule

// ----- design/approach_risk_qualifier.sv -----
// Rear approach risk qualifier. One measurement word in, one result word out,
// one word per clock sustained while out_stall is low: the measurement is
// captured in an input register, validated, classified and run through the
// confirm/clear hysteresis in compare and 32-bit subtract logic, and lands in
// an output register. The result word is valid once its measurement has moved
// from the input register into the output register.
// in_stall rises only when the input register is full and the output
// register holds a word that is stalled. Invalid measurements give a fault
// word and leave the hysteresis state alone. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data); write only while the block is empty.
`timescale 1ns / 1ps
`include "approach_risk_qualifier_macros.svh"

module approach_risk_qualifier (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  logic [arq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arq_pkg::CFG_DATA_W-1:0] cfg_data,
	// measurement channel
	input  logic in_valid,
	output logic in_stall,
	input  logic sensor_healthy,
	input  logic [arq_pkg::CONF_W-1:0] confidence,
	input  logic signed [arq_pkg::MEAS_W-1:0] distance_cm,
	input  logic signed [arq_pkg::MEAS_W-1:0] speed_cm_s,
	input  logic [arq_pkg::TIME_W-1:0] time_ms,
	// result channel
	output logic out_valid,
	input  logic out_stall,
	output logic risk_high,
	output logic [1:0] risk_level,
	output logic risk_valid,
	output logic fault_code
);

	arq_pkg::cfg_t cfg;
	arq_pkg::class_t cls;

	// input register
	logic valid_s1;
	logic healthy_s1;
	logic [arq_pkg::CONF_W-1:0] conf_s1;
	logic signed [arq_pkg::MEAS_W-1:0] dist_s1;
	logic signed [arq_pkg::MEAS_W-1:0] speed_s1;
	logic [arq_pkg::TIME_W-1:0] time_s1;

	// output register
	logic out_valid_q;
	logic risk_high_q;
	logic [1:0] risk_level_q;
	logic risk_valid_q;
	logic fault_code_q;

	logic advance;
	logic in_take;
	logic high_next;

	// stage 1 moves into the output register when that one is free or draining
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	arq_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	arq_classify u_class (
		.cfg(cfg),
		.sensor_healthy(healthy_s1),
		.confidence(conf_s1),
		.distance_cm(dist_s1),
		.speed_cm_s(speed_s1),
		.cls(cls)
	);

	// state is committed when a valid word leaves stage 1, keeping order
	arq_hysteresis u_hyst (
		.clk(clk),
		.arst_n(arst_n),
		.commit(advance),
		.cls(cls),
		.now(time_s1),
		.confirm(cfg.confirm),
		.clear(cfg.clear),
		.high_next(high_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			healthy_s1 <= sensor_healthy;
			conf_s1 <= confidence;
			dist_s1 <= distance_cm;
			speed_s1 <= speed_cm_s;
			time_s1 <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			risk_high_q <= cls.ok && high_next;
			risk_level_q <= cls.level;
			risk_valid_q <= cls.ok;
			fault_code_q <= cls.ok ? arq_pkg::FAULT_NONE : arq_pkg::FAULT_REAR_SENSOR;
		end
	end

	assign out_valid = out_valid_q;
	assign risk_high = risk_high_q;
	assign risk_level = risk_level_q;
	assign risk_valid = risk_valid_q;
	assign fault_code = fault_code_q;

	`ARQ_ASSERT(a_fault_word, clk, arst_n, (out_valid && !risk_valid) |-> (fault_code && !risk_high && (risk_level == arq_pkg::LEVEL_NONE)), "invalid result not a clean fault word")
	`ARQ_ASSERT(a_fault_matches, clk, arst_n, out_valid |-> (risk_valid != fault_code), "fault code disagrees with validity")
	`ARQ_ASSERT(a_stall_needs_full, clk, arst_n, in_stall |-> (valid_s1 && out_valid && out_stall), "input stalled with room in the pipeline")
	`ARQ_ASSERT(a_zero_confirm, clk, arst_n, (advance && cls.ok && cls.threat && (cfg.confirm == '0)) |=> risk_high, "zero confirm time did not raise high risk")

endmodule
